>>> rtl/b64ve_pkg.sv
// shared types, constants and the sextet-to-ascii map of the base64 variant encoder
// depends on nothing; imported by all rtl modules of the block
package b64ve_pkg;

  localparam logic [6:0] PAD_CHAR   = 7'h5B;  // '['
  localparam logic [6:0] CHAR_62    = 7'h2A;  // '*'
  localparam logic [6:0] CHAR_63    = 7'h2D;  // '-'
  localparam logic [6:0] CHAR_UPPER = 7'h41;  // 'A'
  localparam logic [6:0] CHAR_LOWER = 7'h61;  // 'a'
  localparam logic [6:0] CHAR_DIGIT = 7'h30;  // '0'

  localparam logic [1:0] PHASE_EMPTY = 2'd0;
  localparam logic [1:0] PHASE_ONE   = 2'd1;
  localparam logic [1:0] PHASE_TWO   = 2'd2;
  localparam logic [1:0] PHASE_BAD   = 2'd3;

  localparam logic [1:0] SLOT_LAST = 2'd3;

  // one group handed from front to back
  typedef struct packed {
    logic [23:0] block;   // group bits, first byte in 23:16
    logic [1:0]  nbytes;  // data bytes in the group, 1..3
    logic        last;    // group ends the message
  } grp_t;

  typedef struct packed {
    logic valid;
    grp_t grp;
  } grp_push_t;

  typedef struct packed {
    logic       busy;
    logic [1:0] slot;
  } back_sts_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26)      c = CHAR_UPPER + {1'b0, v};
    else if (v < 6'd52) c = CHAR_LOWER + {1'b0, v - 6'd26};
    else if (v < 6'd62) c = CHAR_DIGIT + {1'b0, v - 6'd52};
    else if (v == 6'd62) c = CHAR_62;
    else                 c = CHAR_63;
    return c;
  endfunction

endpackage

>>> rtl/b64ve_front.sv
// front part: takes bytes, collects them into groups of up to three, hands finished groups to the queue
// depends on b64ve_pkg
module b64ve_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // data_byte[7:0]
  input  logic                in_tlast,   // last_byte
  input  logic                q_full,
  output b64ve_pkg::grp_push_t q_push,
  output logic [1:0]          phase
);
  import b64ve_pkg::*;

  logic [1:0]  phase_r, phase_nxt, phase_eff;
  logic [15:0] held_r, held_nxt;
  logic        accept, emit;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign phase_eff = (phase_r == PHASE_BAD) ? PHASE_EMPTY : phase_r;
  assign emit      = in_tlast || (phase_eff == PHASE_TWO);
  assign phase     = phase_r;

  always_comb begin
    q_push.valid      = accept && emit;
    q_push.grp.last   = in_tlast;
    q_push.grp.block  = {in_tdata, 16'h0000};
    q_push.grp.nbytes = 2'd1;
    unique case (phase_eff)
      PHASE_ONE: begin
        q_push.grp.block  = {held_r[15:8], in_tdata, 8'h00};
        q_push.grp.nbytes = 2'd2;
      end
      PHASE_TWO: begin
        q_push.grp.block  = {held_r, in_tdata};
        q_push.grp.nbytes = 2'd3;
      end
      default: begin
        q_push.grp.block  = {in_tdata, 16'h0000};
        q_push.grp.nbytes = 2'd1;
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (accept) begin
      if (emit) begin
        phase_nxt = PHASE_EMPTY;
        held_nxt  = 16'h0000;
      end else if (phase_eff == PHASE_EMPTY) begin
        phase_nxt = PHASE_ONE;
        held_nxt  = {in_tdata, 8'h00};
      end else begin
        phase_nxt = PHASE_TWO;
        held_nxt  = {held_r[15:8], in_tdata};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_EMPTY;
      held_r  <= 16'h0000;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

>>> rtl/b64ve_queue.sv
// short group queue between front and back, register based
// depends on b64ve_pkg
module b64ve_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  b64ve_pkg::grp_push_t push,
  output logic                 full,
  output logic                 pop_valid,
  output b64ve_pkg::grp_t      pop_grp,
  input  logic                 pop,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import b64ve_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  grp_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == CNT_MAX);
  assign pop_valid = (cnt_r != '0);
  assign pop_grp   = mem_r[rd_r];
  assign count     = cnt_r;
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_nxt  = do_push ? ((wr_r == PTR_MAX) ? '0 : wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop  ? ((rd_r == PTR_MAX) ? '0 : rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push.grp;
    end
  end

endmodule

>>> rtl/b64ve_back.sv
// back part: holds one group and sends its four characters, one per cycle while out_tready is high
// depends on b64ve_pkg
module b64ve_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  b64ve_pkg::grp_t     q_grp,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // out_char[6:0], zero [7]
  output logic                out_tlast,  // last_char
  output b64ve_pkg::back_sts_t sts
);
  import b64ve_pkg::*;

  grp_t       cur_r, cur_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [5:0] sextet;
  logic       pad, done;
  logic [6:0] ch;

  always_comb begin
    case (slot_r)
      2'd0:    sextet = cur_r.block[23:18];
      2'd1:    sextet = cur_r.block[17:12];
      2'd2:    sextet = cur_r.block[11:6];
      default: sextet = cur_r.block[5:0];
    endcase
  end

  assign pad        = (slot_r > cur_r.nbytes);
  assign ch         = pad ? PAD_CHAR : sextet_char(sextet);
  assign out_tvalid = busy_r;
  assign out_tdata  = {1'b0, ch};
  assign out_tlast  = cur_r.last && (slot_r == SLOT_LAST);
  assign done       = busy_r && out_tready && (slot_r == SLOT_LAST);
  assign q_pop      = q_valid && (!busy_r || done);
  assign sts.busy   = busy_r;
  assign sts.slot   = slot_r;

  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    if (q_pop) begin
      cur_nxt  = q_grp;
      busy_nxt = 1'b1;
      slot_nxt = 2'd0;
    end else if (done) begin
      busy_nxt = 1'b0;
      slot_nxt = 2'd0;
    end else if (busy_r && out_tready) begin
      slot_nxt = slot_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

>>> rtl/base64_variant_encoder.sv
// top level of the base64 variant encoder: front, group queue and back
// depends on b64ve_pkg, b64ve_front, b64ve_queue, b64ve_back
// a closed group is queued, then loaded into the back before its first character shows
// throughput: one byte a cycle while the queue has room; four characters leave per group,
// one per cycle while out_tready is high, so the single-character output port bounds the rate
// reset: synchronous active-low rst_n empties the queue and clears group phase and back state
module base64_variant_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte[7:0]
  input  logic       in_tlast,   // last_byte
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_char[6:0], zero in bit 7
  output logic       out_tlast   // last_char
);
  import b64ve_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // front to queue
  grp_push_t   q_push;
  logic        q_full;
  logic [1:0]  front_phase;
  // queue to back
  logic        q_valid, q_pop;
  grp_t        q_grp;
  logic [CW-1:0] q_count;
  back_sts_t   back_sts;

  // front: byte collection and group close on third byte or on the last mark
  b64ve_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .phase     (front_phase)
  );

  // queue lets the front keep taking bytes while the back drains characters
  b64ve_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_grp   (q_grp),
    .pop       (q_pop),
    .count     (q_count)
  );

  // back: sextet select, alphabet map, pad and last mark
  b64ve_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_grp      (q_grp),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .sts        (back_sts)
  );

  // a last item always closes the group
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> front_phase == PHASE_EMPTY)
    else $error("group not closed after last item");

  // last mark only on the fourth character of a group
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> back_sts.slot == SLOT_LAST)
    else $error("last mark on wrong character");

  // queue occupancy stays within depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("group queue overflow");

  // a stalled character does not advance the back
  a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(back_sts.slot) && back_sts.busy)
    else $error("back advanced while stalled");

endmodule
